/* sv/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/mpmdm_pkg.sv */
package mpmdm_pkg;

    localparam int Q_W         = 48;
    localparam int M_W         = 47;
    localparam int FRAC        = 24;
    localparam int DIV_NW      = 2 * Q_W;
    localparam int DIV_STEPS   = Q_W;
    localparam int SQ_STEPS    = Q_W;
    localparam int SQ_REM_W    = Q_W + 2;
    localparam int SAT_W       = Q_W + 3;

    localparam int TS_W        = 47;
    localparam int DAMP_W      = 25;
    localparam int DZ_W        = 16;

    localparam int APB_AW      = 5;
    localparam int APB_DW      = 64;
    localparam int REG_IDX_W   = APB_AW - 3;

    localparam logic [REG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DAMPING   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VEL_DZ    = 2'd2;

    localparam logic [TS_W-1:0]   TIME_STEP_RST = 47'd16777;
    localparam logic [DAMP_W-1:0] DAMPING_RST   = 25'd0;
    localparam logic [DZ_W-1:0]   VEL_DZ_RST    = 16'd2;

    localparam logic signed [Q_W-1:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 48'sh8000_0000_0000;

    // Per-node payload carried along the pipeline.
    typedef struct packed {
        logic [M_W-1:0]          m;
        logic [2:0][Q_W-1:0]     f;
        logic [2:0][Q_W-1:0]     p;
        logic [2:0]              bc;
        logic                    last;
    } t_ctx;

    // Flags that ride alongside the final divisions.
    typedef struct packed {
        logic [2:0] bc;
        logic       last;
        logic       mzero;
    } t_tag;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] x);
        logic [3:0] top;
        top = x[SAT_W-1:Q_W-1];
        if ((top == 4'b0000) || (top == 4'b1111)) begin
            return x[Q_W-1:0];
        end
        return x[SAT_W-1] ? Q_MIN : Q_MAX;
    endfunction

    function automatic logic [Q_W-1:0] mag_q(input logic signed [Q_W-1:0] x);
        return x[Q_W-1] ? Q_W'(-x) : x;
    endfunction

endpackage

/* sv/mpmdm_if.sv */
interface mpmdm_node_if;
    logic               valid;
    logic               ready;
    logic [46:0]        node_mass;
    logic signed [47:0] ext_force_x;
    logic signed [47:0] ext_force_y;
    logic signed [47:0] ext_force_z;
    logic signed [47:0] int_force_x;
    logic signed [47:0] int_force_y;
    logic signed [47:0] int_force_z;
    logic signed [47:0] momentum_x;
    logic signed [47:0] momentum_y;
    logic signed [47:0] momentum_z;
    logic [2:0]         bc_mask;
    logic               node_last;

    modport source (
        output valid, node_mass, ext_force_x, ext_force_y, ext_force_z,
               int_force_x, int_force_y, int_force_z,
               momentum_x, momentum_y, momentum_z, bc_mask, node_last,
        input  ready
    );
    modport sink (
        input  valid, node_mass, ext_force_x, ext_force_y, ext_force_z,
               int_force_x, int_force_y, int_force_z,
               momentum_x, momentum_y, momentum_z, bc_mask, node_last,
        output ready
    );
endinterface

interface mpmdm_result_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] accel_x;
    logic signed [47:0] accel_y;
    logic signed [47:0] accel_z;
    logic signed [47:0] vel_x;
    logic signed [47:0] vel_y;
    logic signed [47:0] vel_z;
    logic               pass_last;

    modport source (
        output valid, accel_x, accel_y, accel_z, vel_x, vel_y, vel_z, pass_last,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, vel_x, vel_y, vel_z, pass_last,
        output ready
    );
endinterface

/* sv/mpm_nodal_damped_momentum_update.sv */
// Nodal momentum update with local damping for a material point mesh.
// Input channel i_node carries one mesh node per item: mass, external and
// internal force and momentum per axis, a free-axis mask and a pass marker.
// Output channel o_result returns one item per node: acceleration and
// updated velocity per axis (Q24.24, saturated) and a copy of the marker.
// Both channels use valid/ready; an item moves when both are high.
// Registers (time step, damping, velocity deadzone) sit on the APB port at
// byte addresses 0, 8 and 16; write them only while the block is empty.
// Throughput is one node per cycle while o_result is not stalled. A node
// passes 106 register stages: four stages of force and sum of squares,
// 48 of square root alongside the velocity divides, five of damping and
// numerator forming, 48 of the final divides, and the output register.
// The two 48-stage units produce one bit per stage.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and i_node.ready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads the register defaults.
module mpm_nodal_damped_momentum_update (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mpmdm_pkg::APB_AW-1:0]      paddr,
    input  logic [mpmdm_pkg::APB_DW-1:0]      pwdata,
    output logic [mpmdm_pkg::APB_DW-1:0]      prdata,
    output logic                              pready,
    mpmdm_node_if.sink                        i_node,
    mpmdm_result_if.source                    o_result
);
    import mpmdm_pkg::*;
    `include "assert_macros.svh"

    localparam int LAT = 4 + SQ_STEPS + 5 + DIV_STEPS + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TS_W-1:0]   r_time_step;
    logic [DAMP_W-1:0] r_damping;
    logic [DZ_W-1:0]   r_vel_dz;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RST;
            r_damping   <= DAMPING_RST;
            r_vel_dz    <= VEL_DZ_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[APB_AW-1:3])
                REG_TIME_STEP: r_time_step <= pwdata[TS_W-1:0];
                REG_DAMPING:   r_damping   <= pwdata[DAMP_W-1:0];
                REG_VEL_DZ:    r_vel_dz    <= pwdata[DZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_AW-1:3])
            REG_TIME_STEP: prdata = APB_DW'(r_time_step);
            REG_DAMPING:   prdata = APB_DW'(r_damping);
            REG_VEL_DZ:    prdata = APB_DW'(r_vel_dz);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together; hold all when the
    // output register is full and the receiver is not taking it.
    // ------------------------------------------------------------------
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en          = !r_vld[LAT-1] || o_result.ready;
    assign i_node.ready  = w_en;
    assign o_result.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_node.valid};
        end
    end

    // ------------------------------------------------------------------
    // A1: net force, saturated
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] w_ext [3];
    logic signed [Q_W-1:0] w_int [3];
    logic signed [Q_W-1:0] w_mom [3];
    t_ctx                  n_a1_ctx;
    t_ctx                  r_a1_ctx;

    assign w_ext[0] = i_node.ext_force_x;
    assign w_ext[1] = i_node.ext_force_y;
    assign w_ext[2] = i_node.ext_force_z;
    assign w_int[0] = i_node.int_force_x;
    assign w_int[1] = i_node.int_force_y;
    assign w_int[2] = i_node.int_force_z;
    assign w_mom[0] = i_node.momentum_x;
    assign w_mom[1] = i_node.momentum_y;
    assign w_mom[2] = i_node.momentum_z;

    always_comb begin
        n_a1_ctx.m    = i_node.node_mass;
        n_a1_ctx.bc   = i_node.bc_mask;
        n_a1_ctx.last = i_node.node_last;
        for (int k = 0; k < 3; k++) begin
            n_a1_ctx.f[k] = sat_q(SAT_W'(w_ext[k]) - SAT_W'(w_int[k]));
            n_a1_ctx.p[k] = w_mom[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a1_ctx <= n_a1_ctx;
        end
    end

    // ------------------------------------------------------------------
    // A2: partial products of |F|^2 on 24-bit halves
    // ------------------------------------------------------------------
    logic [Q_W-1:0] r_a2_pp00 [3];
    logic [Q_W-1:0] r_a2_pp01 [3];
    logic [Q_W-1:0] r_a2_pp11 [3];
    t_ctx           r_a2_ctx;

    for (genvar k = 0; k < 3; k++) begin : g_sq
        logic [Q_W-1:0]  w_fm;
        logic [FRAC-1:0] w_lo;
        logic [FRAC-1:0] w_hi;

        assign w_fm = mag_q(r_a1_ctx.f[k]);
        assign w_lo = w_fm[FRAC-1:0];
        assign w_hi = w_fm[Q_W-1:FRAC];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_a2_pp00[k] <= w_lo * w_lo;
                r_a2_pp01[k] <= w_lo * w_hi;
                r_a2_pp11[k] <= w_hi * w_hi;
            end
        end
    end

    // A3: each square; A4: sum over the axes
    logic [DIV_NW-1:0] r_a3_sq [3];
    logic [DIV_NW-1:0] r_a4_ss;
    t_ctx              r_a3_ctx;
    t_ctx              r_a4_ctx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a2_ctx <= r_a1_ctx;
            r_a3_ctx <= r_a2_ctx;
            r_a4_ctx <= r_a3_ctx;
            for (int k = 0; k < 3; k++) begin
                r_a3_sq[k] <= {r_a2_pp11[k], {Q_W{1'b0}}}
                            + {23'd0, r_a2_pp01[k], 25'd0}
                            + {{Q_W{1'b0}}, r_a2_pp00[k]};
            end
            r_a4_ss <= r_a3_sq[0] + r_a3_sq[1] + r_a3_sq[2];
        end
    end

    // ------------------------------------------------------------------
    // B: norm by digit-by-digit square root, one root bit per stage, with
    // the three velocity divides running alongside.
    // ------------------------------------------------------------------
    logic [SQ_REM_W-1:0] r_sq_rem  [SQ_STEPS];
    logic [Q_W-1:0]      r_sq_root [SQ_STEPS];
    logic [DIV_NW-1:0]   r_sq_rad  [SQ_STEPS];
    t_ctx                r_b_ctx   [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [SQ_REM_W-1:0] w_rem_in;
        logic [Q_W-1:0]      w_root_in;
        logic [DIV_NW-1:0]   w_rad_in;
        t_ctx                w_ctx_in;
        logic [SQ_REM_W+1:0] w_x;
        logic [SQ_REM_W+1:0] w_trial;
        logic [SQ_REM_W+1:0] w_diff;
        logic                w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = r_a4_ss;
            assign w_ctx_in  = r_a4_ctx;
        end else begin : g_rest
            assign w_rem_in  = r_sq_rem[k-1];
            assign w_root_in = r_sq_root[k-1];
            assign w_rad_in  = r_sq_rad[k-1];
            assign w_ctx_in  = r_b_ctx[k-1];
        end

        assign w_x     = {w_rem_in, w_rad_in[DIV_NW-1:DIV_NW-2]};
        assign w_trial = {2'b00, w_root_in, 2'b01};
        assign w_diff  = w_x - w_trial;
        assign w_ge    = (w_x >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k]  <= w_ge ? w_diff[SQ_REM_W-1:0] : w_x[SQ_REM_W-1:0];
                r_sq_root[k] <= {w_root_in[Q_W-2:0], w_ge};
                r_sq_rad[k]  <= {w_rad_in[DIV_NW-3:0], 2'b00};
                r_b_ctx[k]   <= w_ctx_in;
            end
        end
    end

    logic signed [Q_W-1:0] w_v [3];

    for (genvar k = 0; k < 3; k++) begin : g_vdiv
        mpmdm_div u_vdiv (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  ({{FRAC{1'b0}}, mag_q(r_a4_ctx.p[k]), {FRAC{1'b0}}}),
            .i_den  (r_a4_ctx.m),
            .i_neg  (r_a4_ctx.p[k][Q_W-1]),
            .o_quot (w_v[k])
        );
    end

    // ------------------------------------------------------------------
    // C1: hold velocity, damping * norm in two partial products
    // ------------------------------------------------------------------
    logic [Q_W-1:0]           w_norm;
    logic signed [Q_W-1:0]    r_c1_v [3];
    logic [DAMP_W+FRAC-1:0]   r_c1_dn0;
    logic [DAMP_W+FRAC-1:0]   r_c1_dn1;
    t_ctx                     r_c1_ctx;

    assign w_norm = r_sq_root[SQ_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_c1_v[k] <= w_v[k];
            end
            r_c1_dn0 <= r_damping * w_norm[FRAC-1:0];
            r_c1_dn1 <= r_damping * w_norm[Q_W-1:FRAC];
            r_c1_ctx <= r_b_ctx[SQ_STEPS-1];
        end
    end

    // ------------------------------------------------------------------
    // C2: damping term, applied against the velocity sign outside the
    // deadzone
    // ------------------------------------------------------------------
    logic [DAMP_W+Q_W-1:0]  w_term_sum;
    logic [DAMP_W+FRAC-1:0] w_term;
    logic signed [SAT_W-1:0] w_term_s;
    t_ctx                   n_c2_ctx;
    t_ctx                   r_c2_ctx;

    assign w_term_sum = {r_c1_dn1, {FRAC{1'b0}}} + {{FRAC{1'b0}}, r_c1_dn0};
    assign w_term     = w_term_sum[DAMP_W+Q_W-1:FRAC];
    assign w_term_s   = $signed({2'b00, w_term});

    always_comb begin
        logic signed [Q_W-1:0] f_cur;
        logic                  damp;
        n_c2_ctx = r_c1_ctx;
        for (int k = 0; k < 3; k++) begin
            f_cur = r_c1_ctx.f[k];
            damp  = (mag_q(r_c1_v[k]) >= {{(Q_W-DZ_W){1'b0}}, r_vel_dz})
                 && (r_c1_v[k] != '0);
            if (damp) begin
                if (r_c1_v[k][Q_W-1]) begin
                    n_c2_ctx.f[k] = sat_q(SAT_W'(f_cur) + w_term_s);
                end else begin
                    n_c2_ctx.f[k] = sat_q(SAT_W'(f_cur) - w_term_s);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2_ctx <= n_c2_ctx;
        end
    end

    // ------------------------------------------------------------------
    // C3: dt * |F| in four partial products
    // ------------------------------------------------------------------
    logic [Q_W-1:0] r_c3_q00 [3];
    logic [Q_W-1:0] r_c3_q01 [3];
    logic [Q_W-1:0] r_c3_q10 [3];
    logic [Q_W-1:0] r_c3_q11 [3];
    t_ctx           r_c3_ctx;

    for (genvar k = 0; k < 3; k++) begin : g_dtf
        logic [Q_W-1:0]       w_fm;
        logic [FRAC-1:0]      w_a0;
        logic [FRAC-1:0]      w_a1;
        logic [FRAC-1:0]      w_t0;
        logic [TS_W-FRAC-1:0] w_t1;

        assign w_fm = mag_q(r_c2_ctx.f[k]);
        assign w_a0 = w_fm[FRAC-1:0];
        assign w_a1 = w_fm[Q_W-1:FRAC];
        assign w_t0 = r_time_step[FRAC-1:0];
        assign w_t1 = r_time_step[TS_W-1:FRAC];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c3_q00[k] <= w_t0 * w_a0;
                r_c3_q01[k] <= w_t0 * w_a1;
                r_c3_q10[k] <= w_t1 * w_a0;
                r_c3_q11[k] <= w_t1 * w_a1;
            end
        end
    end

    // ------------------------------------------------------------------
    // C4: signed dt*F and signed p << 24; C5: velocity numerator magnitude
    // ------------------------------------------------------------------
    logic signed [DIV_NW:0] r_c4_fw [3];
    logic signed [DIV_NW:0] r_c4_pw [3];
    logic [DIV_NW-1:0]      r_c5_vnum [3];
    logic                   r_c5_vneg [3];
    t_ctx                   r_c4_ctx;
    t_ctx                   r_c5_ctx;

    for (genvar k = 0; k < 3; k++) begin : g_num
        logic [Q_W:0]           w_mid;
        logic [DIV_NW-1:0]      w_fw;
        logic [DIV_NW:0]        w_pw;
        logic signed [DIV_NW:0] w_num;
        logic                   w_neg;

        assign w_mid = {1'b0, r_c3_q01[k]} + {1'b0, r_c3_q10[k]};
        assign w_fw  = {r_c3_q11[k], {Q_W{1'b0}}}
                     + {23'd0, w_mid, {FRAC{1'b0}}}
                     + {{Q_W{1'b0}}, r_c3_q00[k]};
        assign w_pw  = {25'd0, mag_q(r_c3_ctx.p[k]), {FRAC{1'b0}}};
        assign w_num = r_c4_pw[k] + r_c4_fw[k];
        assign w_neg = w_num[DIV_NW];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c4_fw[k]   <= r_c3_ctx.f[k][Q_W-1] ? -$signed({1'b0, w_fw})
                                                      :  $signed({1'b0, w_fw});
                r_c4_pw[k]   <= r_c3_ctx.p[k][Q_W-1] ? -$signed(w_pw) : $signed(w_pw);
                r_c5_vneg[k] <= w_neg;
                r_c5_vnum[k] <= w_neg ? DIV_NW'(-w_num) : w_num[DIV_NW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c3_ctx <= r_c2_ctx;
            r_c4_ctx <= r_c3_ctx;
            r_c5_ctx <= r_c4_ctx;
        end
    end

    // ------------------------------------------------------------------
    // D: acceleration and velocity divides, flags alongside
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] w_acc [3];
    logic signed [Q_W-1:0] w_vel [3];
    t_tag                  r_d_tag [DIV_STEPS];
    t_tag                  w_tag_in;

    for (genvar k = 0; k < 3; k++) begin : g_odiv
        mpmdm_div u_adiv (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  ({{FRAC{1'b0}}, mag_q(r_c5_ctx.f[k]), {FRAC{1'b0}}}),
            .i_den  (r_c5_ctx.m),
            .i_neg  (r_c5_ctx.f[k][Q_W-1]),
            .o_quot (w_acc[k])
        );
        mpmdm_div u_vdiv (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_c5_vnum[k]),
            .i_den  (r_c5_ctx.m),
            .i_neg  (r_c5_vneg[k]),
            .o_quot (w_vel[k])
        );
    end

    assign w_tag_in.bc    = r_c5_ctx.bc;
    assign w_tag_in.last  = r_c5_ctx.last;
    assign w_tag_in.mzero = (r_c5_ctx.m == '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_tag[0] <= w_tag_in;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_d_tag[k] <= r_d_tag[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: zero fixed axes and zero-mass nodes
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] r_out_acc [3];
    logic signed [Q_W-1:0] r_out_vel [3];
    logic                  r_out_last;
    logic [2:0]            r_out_bc;
    logic                  r_out_mz;
    t_tag                  w_tag_out;

    assign w_tag_out = r_d_tag[DIV_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                if (w_tag_out.bc[k] && !w_tag_out.mzero) begin
                    r_out_acc[k] <= w_acc[k];
                    r_out_vel[k] <= w_vel[k];
                end else begin
                    r_out_acc[k] <= '0;
                    r_out_vel[k] <= '0;
                end
            end
            r_out_last <= w_tag_out.last;
            r_out_bc   <= w_tag_out.bc;
            r_out_mz   <= w_tag_out.mzero;
        end
    end

    assign o_result.accel_x   = r_out_acc[0];
    assign o_result.accel_y   = r_out_acc[1];
    assign o_result.accel_z   = r_out_acc[2];
    assign o_result.vel_x     = r_out_vel[0];
    assign o_result.vel_y     = r_out_vel[1];
    assign o_result.vel_z     = r_out_vel[2];
    assign o_result.pass_last = r_out_last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_zero_mass_zero_out, i_clk, i_rst_n,
        o_result.valid && r_out_mz,
        (r_out_acc[0] == '0) && (r_out_acc[1] == '0) && (r_out_acc[2] == '0) &&
        (r_out_vel[0] == '0) && (r_out_vel[1] == '0) && (r_out_vel[2] == '0))
    `ASSERT_IMPL(a_fixed_x_zero, i_clk, i_rst_n,
        o_result.valid && !r_out_bc[0],
        (r_out_acc[0] == '0) && (r_out_vel[0] == '0))
    `ASSERT_NEXT(a_stall_holds_line, i_clk, i_rst_n, !w_en, $stable(r_vld))

endmodule

/* sv/mpmdm_div.sv */
module mpmdm_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [mpmdm_pkg::DIV_NW-1:0]        i_num,
    input  logic [mpmdm_pkg::M_W-1:0]           i_den,
    input  logic                                i_neg,
    output logic signed [mpmdm_pkg::Q_W-1:0]    o_quot
);
    import mpmdm_pkg::*;

    // One quotient bit per stage, restoring form.
    logic [M_W-1:0] r_rem [DIV_STEPS];
    logic [Q_W-1:0] r_lo  [DIV_STEPS];
    logic [Q_W-1:0] r_quo [DIV_STEPS];
    logic [M_W-1:0] r_den [DIV_STEPS];
    logic           r_neg [DIV_STEPS];
    logic           r_ovf [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [M_W-1:0] w_rem_in;
        logic [Q_W-1:0] w_lo_in;
        logic [Q_W-1:0] w_quo_in;
        logic [M_W-1:0] w_den_in;
        logic           w_neg_in;
        logic           w_ovf_in;
        logic [Q_W-1:0] w_x;
        logic [Q_W-1:0] w_diff;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = i_num[DIV_NW-2:Q_W];
            assign w_lo_in  = i_num[Q_W-1:0];
            assign w_quo_in = '0;
            assign w_den_in = i_den;
            assign w_neg_in = i_neg;
            // quotient of 2^48 or more saturates whatever the sign
            assign w_ovf_in = (i_num[DIV_NW-1:Q_W] >= {1'b0, i_den});
        end else begin : g_rest
            assign w_rem_in = r_rem[k-1];
            assign w_lo_in  = r_lo[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_den_in = r_den[k-1];
            assign w_neg_in = r_neg[k-1];
            assign w_ovf_in = r_ovf[k-1];
        end

        assign w_x    = {w_rem_in, w_lo_in[Q_W-1]};
        assign w_diff = w_x - {1'b0, w_den_in};
        assign w_ge   = (w_x >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[M_W-1:0] : w_x[M_W-1:0];
                r_lo[k]  <= {w_lo_in[Q_W-2:0], 1'b0};
                r_quo[k] <= {w_quo_in[Q_W-2:0], w_ge};
                r_den[k] <= w_den_in;
                r_neg[k] <= w_neg_in;
                r_ovf[k] <= w_ovf_in;
            end
        end
    end

    logic [Q_W-1:0] w_q;
    logic           w_big;

    assign w_q = r_quo[DIV_STEPS-1];

    always_comb begin
        if (r_neg[DIV_STEPS-1]) begin
            w_big  = r_ovf[DIV_STEPS-1] || (w_q[Q_W-1] && (w_q[Q_W-2:0] != '0));
            o_quot = w_big ? Q_MIN : Q_W'(-w_q);
        end else begin
            w_big  = r_ovf[DIV_STEPS-1] || w_q[Q_W-1];
            o_quot = w_big ? Q_MAX : w_q;
        end
    end

endmodule
